// ----- hdl/pbmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pbmc_pkg: shared types and constants
// control codes, limit modes, register map and state records of the
// prescaled bounded mode counter
// ----------------------------------------------------------------------------
package pbmc_pkg;

  // counter value width, fixed by the 32-bit value and limit fields
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PeriodWidth = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = 5;

  typedef logic signed [ValueWidth-1:0] value_t;

  localparam logic [PeriodWidth-1:0] ResetPeriod = PeriodWidth'(10);
  localparam value_t ResetStep = value_t'(1);
  localparam value_t ResetLow = value_t'(0);
  localparam value_t ResetHigh = value_t'(100);

  typedef enum logic [1:0] {
    CtlStopped = 2'd0,
    CtlRun     = 2'd1,
    CtlRewind  = 2'd2,
    CtlFfwd    = 2'd3
  } ctl_e;

  typedef enum logic [2:0] {
    LmStop    = 3'd0,
    LmLoop    = 3'd1,
    LmShuttle = 3'd2,
    LmDownUp  = 3'd3,
    LmUpDown  = 3'd4
  } lmode_e;

  typedef enum logic [2:0] {
    RegPeriod    = 3'd0,
    RegStepSize  = 3'd1,
    RegLowLimit  = 3'd2,
    RegHighLimit = 3'd3,
    RegLimitMode = 3'd4
  } reg_e;

  typedef struct packed {
    logic [PeriodWidth-1:0] period;
    value_t                 step_size;
    value_t                 low_limit;
    value_t                 high_limit;
    logic [2:0]             limit_mode;
  } cfg_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] tick;
    value_t                 value;
    ctl_e                   ctl;
    logic                   reversed;
  } state_t;

endpackage

// ----- hdl/pbmc_in_if.sv -----
// ----------------------------------------------------------------------------
// pbmc_in_if: input word channel
// valid/ready channel carrying one tick or control write
// ----------------------------------------------------------------------------
interface pbmc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] control_value;

  modport source (output valid, output mode, output control_value, input ready);
  modport sink (input valid, input mode, input control_value, output ready);
endinterface

// ----- hdl/pbmc_out_if.sv -----
// ----------------------------------------------------------------------------
// pbmc_out_if: result word channel
// valid/ready channel carrying the counter value after each input word
// ----------------------------------------------------------------------------
interface pbmc_out_if;
  logic                             valid;
  logic                             ready;
  logic [pbmc_pkg::ValueWidth-1:0]  count_value;
  logic                             stepped;
  logic [1:0]                       control_now;

  modport source (output valid, output count_value, output stepped, output control_now,
                  input ready);
  modport sink (input valid, input count_value, input stepped, input control_now,
                output ready);
endinterface

// ----- hdl/prescaled_bounded_mode_counter_top.sv -----
// ----------------------------------------------------------------------------
// prescaled_bounded_mode_counter_top: prescaled bounded mode counter
// tick-driven counter with period prescaler, control state and five limit modes
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    mode, control_value
//  out_o     out  valid / ready    count_value, stepped, control_now
//  apb       in   psel / penable   paddr, pwdata (write), prdata (read)
//
//  one word per cycle sustained while out_o is ready; a word waits in the input register
//  the input register feeds the update logic, the result register and the counter
//  state load on the same edge, so each word sees the state left by the one before
//  reset: value 0, prescaler 0, control run, step not reversed, registers 10/1/0/100/0
//  a stalled result holds the input register; the input still takes a word while empty
//
module prescaled_bounded_mode_counter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pbmc_in_if.sink                        in_i,
  pbmc_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbmc_pkg::AddrWidth-1:0] paddr,
  input  logic [pbmc_pkg::DataWidth-1:0] pwdata,
  output logic [pbmc_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  pbmc_pkg::cfg_t   cfg;
  logic             step_clr;

  // input register
  logic             s1_valid_q;
  logic             s1_mode_q;
  logic [1:0]       s1_ctl_q;
  logic             s1_adv;
  logic             in_acc;

  // counter state
  pbmc_pkg::state_t state_q, state_d;
  logic             stepped_d;

  // result register
  logic             out_valid_q;
  pbmc_pkg::value_t out_value_q;
  logic             out_stepped_q;
  pbmc_pkg::ctl_e   out_ctl_q;

  pbmc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_o      (cfg),
    .step_clr_o (step_clr)
  );

  pbmc_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .item_mode_i (s1_mode_q),
    .item_ctl_i  (s1_ctl_q),
    .state_o     (state_d),
    .stepped_o   (stepped_d)
  );

  // word moves from input register to result register when that slot frees up
  assign s1_adv = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= in_i.mode;
      s1_ctl_q <= in_i.control_value;
    end
  end

  // counter state; a step size write clears the reversal
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tick <= '0;
      state_q.value <= '0;
      state_q.ctl <= pbmc_pkg::CtlRun;
      state_q.reversed <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_q.tick <= state_d.tick;
        state_q.value <= state_d.value;
        state_q.ctl <= state_d.ctl;
      end
      state_q.reversed <= !step_clr && (s1_adv ? state_d.reversed : state_q.reversed);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= state_d.value;
      out_stepped_q <= stepped_d;
      out_ctl_q <= state_d.ctl;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.count_value = out_value_q;
  assign out_o.stepped = out_stepped_q;
  assign out_o.control_now = out_ctl_q;

`ifndef SYNTHESIS
  // any step leaves the control in run
  a_step_leaves_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stepped_q |-> out_ctl_q == pbmc_pkg::CtlRun)
    else $error("stepped result with control other than run");

  // a tick while stopped neither moves the value nor steps
  a_stopped_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_mode_q && state_q.ctl == pbmc_pkg::CtlStopped
    |=> $stable(state_q.value) && !out_stepped_q)
    else $error("counter moved while stopped");

  // prescaler restarts on every step
  a_tick_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && stepped_d |=> state_q.tick == '0)
    else $error("prescaler not cleared after step");
`endif

endmodule

// ----- hdl/pbmc_cfg.sv -----
// ----------------------------------------------------------------------------
// pbmc_cfg: configuration registers
// apb register file for period, step, limits and limit mode
// ----------------------------------------------------------------------------
module pbmc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbmc_pkg::AddrWidth-1:0] paddr,
  input  logic [pbmc_pkg::DataWidth-1:0] pwdata,
  output logic [pbmc_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output pbmc_pkg::cfg_t                 cfg_o,
  output logic                           step_clr_o
);

  pbmc_pkg::cfg_t cfg_q;
  pbmc_pkg::reg_e reg_sel;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_sel = pbmc_pkg::reg_e'(paddr[pbmc_pkg::AddrWidth-1:2]);
  assign step_clr_o = wr_en && (reg_sel == pbmc_pkg::RegStepSize);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period <= pbmc_pkg::ResetPeriod;
      cfg_q.step_size <= pbmc_pkg::ResetStep;
      cfg_q.low_limit <= pbmc_pkg::ResetLow;
      cfg_q.high_limit <= pbmc_pkg::ResetHigh;
      cfg_q.limit_mode <= pbmc_pkg::LmStop;
    end else if (wr_en) begin
      case (reg_sel)
        pbmc_pkg::RegPeriod:    cfg_q.period <= pwdata[pbmc_pkg::PeriodWidth-1:0];
        pbmc_pkg::RegStepSize:  cfg_q.step_size <= pwdata;
        pbmc_pkg::RegLowLimit:  cfg_q.low_limit <= pwdata;
        pbmc_pkg::RegHighLimit: cfg_q.high_limit <= pwdata;
        pbmc_pkg::RegLimitMode: cfg_q.limit_mode <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // read mux, unmapped addresses read zero
  always_comb begin
    prdata = '0;
    case (reg_sel)
      pbmc_pkg::RegPeriod:    prdata = {{(pbmc_pkg::DataWidth-pbmc_pkg::PeriodWidth){1'b0}},
                                        cfg_q.period};
      pbmc_pkg::RegStepSize:  prdata = cfg_q.step_size;
      pbmc_pkg::RegLowLimit:  prdata = cfg_q.low_limit;
      pbmc_pkg::RegHighLimit: prdata = cfg_q.high_limit;
      pbmc_pkg::RegLimitMode: prdata = {{(pbmc_pkg::DataWidth-3){1'b0}}, cfg_q.limit_mode};
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- hdl/pbmc_step.sv -----
// ----------------------------------------------------------------------------
// pbmc_step: counter update logic
// prescaler, control handling and limit modes for one input word
// ----------------------------------------------------------------------------
module pbmc_step (
  input  pbmc_pkg::cfg_t   cfg_i,
  input  pbmc_pkg::state_t state_i,
  input  logic             item_mode_i,
  input  logic [1:0]       item_ctl_i,
  output pbmc_pkg::state_t state_o,
  output logic             stepped_o
);

  localparam int unsigned W = pbmc_pkg::ValueWidth;

  typedef logic signed [W+1:0] wide_t;

  localparam pbmc_pkg::value_t VMax = {1'b0, {(W-1){1'b1}}};
  localparam pbmc_pkg::value_t VMin = {1'b1, {(W-1){1'b0}}};
  localparam pbmc_pkg::value_t One = pbmc_pkg::value_t'(1);

  function automatic wide_t widen(input pbmc_pkg::value_t a);
    return {{2{a[W-1]}}, a};
  endfunction

  // clamp a two-bit-wider result back to the value range
  function automatic pbmc_pkg::value_t clamp(input wide_t x);
    pbmc_pkg::value_t r;
    if (x > widen(VMax)) begin
      r = VMax;
    end else if (x < widen(VMin)) begin
      r = VMin;
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  function automatic pbmc_pkg::value_t sadd(input pbmc_pkg::value_t a,
                                            input pbmc_pkg::value_t b);
    return clamp(widen(a) + widen(b));
  endfunction

  function automatic pbmc_pkg::value_t ssub(input pbmc_pkg::value_t a,
                                            input pbmc_pkg::value_t b);
    return clamp(widen(a) - widen(b));
  endfunction

  pbmc_pkg::value_t       lo, hi, v, run_value;
  wide_t                  step_w;
  logic                   run_rev;
  logic [pbmc_pkg::PeriodWidth-1:0] tick_inc;

  assign lo = cfg_i.low_limit;
  assign hi = cfg_i.high_limit;
  assign tick_inc = state_i.tick + pbmc_pkg::PeriodWidth'(1);

  // effective step may be the negated minimum, kept exact in the wide form
  assign step_w = state_i.reversed ? -widen(cfg_i.step_size) : widen(cfg_i.step_size);
  assign v = clamp(widen(state_i.value) + step_w);

  // run step: add, then keep within limits per mode
  always_comb begin
    run_value = v;
    run_rev = state_i.reversed;
    if (hi == lo) begin
      run_value = hi;
    end else begin
      case (pbmc_pkg::lmode_e'(cfg_i.limit_mode))
        pbmc_pkg::LmStop: begin
          // clamp to high first, then to low, so crossed limits end on low
          if (v > hi) begin
            run_value = (hi < lo) ? lo : hi;
          end else if (v < lo) begin
            run_value = lo;
          end
        end
        pbmc_pkg::LmLoop: begin
          if (v > hi) begin
            run_value = ssub(sadd(lo, ssub(v, hi)), One);
          end else if (v < lo) begin
            run_value = sadd(ssub(hi, ssub(lo, v)), One);
          end
        end
        pbmc_pkg::LmShuttle: begin
          if (v > hi) begin
            run_value = ssub(hi, ssub(v, hi));
            run_rev = !state_i.reversed;
          end else if (v < lo) begin
            run_value = sadd(lo, ssub(lo, v));
            run_rev = !state_i.reversed;
          end
        end
        pbmc_pkg::LmDownUp: begin
          if (v < lo) begin
            run_value = sadd(lo, ssub(lo, v));
            run_rev = !state_i.reversed;
          end else if (v > hi) begin
            run_value = hi;
          end
        end
        pbmc_pkg::LmUpDown: begin
          if (v > hi) begin
            run_value = ssub(hi, ssub(v, hi));
            run_rev = !state_i.reversed;
          end else if (v < lo) begin
            run_value = lo;
          end
        end
        default: ;
      endcase
    end
  end

  // prescaler and control
  always_comb begin
    state_o = state_i;
    stepped_o = 1'b0;
    if (item_mode_i) begin
      state_o.ctl = pbmc_pkg::ctl_e'(item_ctl_i);
    end else if (state_i.ctl != pbmc_pkg::CtlStopped) begin
      state_o.tick = tick_inc;
      if (tick_inc >= cfg_i.period) begin
        state_o.tick = '0;
        stepped_o = 1'b1;
        case (state_i.ctl)
          pbmc_pkg::CtlRun: begin
            state_o.value = run_value;
            state_o.reversed = run_rev;
          end
          pbmc_pkg::CtlRewind: begin
            state_o.value = lo;
            state_o.ctl = pbmc_pkg::CtlRun;
          end
          pbmc_pkg::CtlFfwd: begin
            state_o.value = hi;
            state_o.ctl = pbmc_pkg::CtlRun;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sim/prescaled_bounded_mode_counter_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prescaled_bounded_mode_counter_top_tb: counter testbench
// drives tick and control words with random gaps and result stalls, keeps a
// word-level copy of the counter and checks every result word in order
// ----------------------------------------------------------------------------
module prescaled_bounded_mode_counter_top_tb;

  // input word kinds
  localparam logic ModeTick     = 1'b0;
  localparam logic ModeCtlWrite = 1'b1;

  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned RandomWords = 1550;

  localparam pbmc_pkg::value_t MaxValue = 32'sh7fff_ffff;
  localparam pbmc_pkg::value_t MinValue = 32'sh8000_0000;

  // one expected result word
  typedef struct packed {
    pbmc_pkg::value_t count;
    logic             stepped;
    pbmc_pkg::ctl_e   ctl;
  } count_word_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [pbmc_pkg::AddrWidth-1:0]   paddr;
  logic [pbmc_pkg::DataWidth-1:0]   pwdata;
  logic [pbmc_pkg::DataWidth-1:0]   prdata;
  logic                             pready;

  pbmc_in_if  in_ch();
  pbmc_out_if out_ch();

  prescaled_bounded_mode_counter_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the registers
  logic [pbmc_pkg::PeriodWidth-1:0] cfg_period;
  pbmc_pkg::value_t                 cfg_step;
  pbmc_pkg::value_t                 cfg_low;
  pbmc_pkg::value_t                 cfg_high;
  logic [2:0]                       cfg_lmode;

  // local copy of the counter state
  logic [pbmc_pkg::PeriodWidth-1:0] prescale_cnt;
  pbmc_pkg::value_t                 count_val;
  pbmc_pkg::ctl_e                   ctl_state;
  logic                             step_flip;

  // results still owed by the block, oldest first
  count_word_t pending_counts[$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt;

  // random idling on each side, switched off for a stretch of the run
  bit sender_gaps;
  bit receiver_gaps;

  // --------------------------------------------------------------------------
  // counter arithmetic
  // --------------------------------------------------------------------------

  // saturate to the 32-bit signed value range
  function automatic longint clip32(input longint a);
    if (a > longint'(MaxValue)) return longint'(MaxValue);
    if (a < longint'(MinValue)) return longint'(MinValue);
    return a;
  endfunction

  function automatic void reset_counter_model();
    cfg_period   = pbmc_pkg::ResetPeriod;
    cfg_step     = pbmc_pkg::ResetStep;
    cfg_low      = pbmc_pkg::ResetLow;
    cfg_high     = pbmc_pkg::ResetHigh;
    cfg_lmode    = pbmc_pkg::LmStop;
    prescale_cnt = '0;
    count_val    = '0;
    ctl_state    = pbmc_pkg::CtlRun;
    step_flip    = 1'b0;
  endfunction

  // one run step: add the step, then keep the value inside the limits
  function automatic void bounded_step();
    longint lo;
    longint hi;
    longint st;
    longint v;
    lo = cfg_low;
    hi = cfg_high;
    st = step_flip ? -longint'(cfg_step) : longint'(cfg_step);
    v  = clip32(longint'(count_val) + st);
    // equal limits pin the value whatever the mode
    if (hi == lo) begin
      count_val = pbmc_pkg::value_t'(hi);
      return;
    end
    // crossed limits just run through the tests in order
    case (cfg_lmode)
      pbmc_pkg::LmStop: begin
        if (v > hi) v = hi;
        if (v < lo) v = lo;
      end
      pbmc_pkg::LmLoop: begin
        if (v > hi) v = clip32(clip32(lo + clip32(v - hi)) - 1);
        else if (v < lo) v = clip32(clip32(hi - clip32(lo - v)) + 1);
      end
      pbmc_pkg::LmShuttle: begin
        if (v > hi) begin
          v = clip32(hi - clip32(v - hi));
          step_flip = !step_flip;
        end else if (v < lo) begin
          v = clip32(lo + clip32(lo - v));
          step_flip = !step_flip;
        end
      end
      pbmc_pkg::LmDownUp: begin
        if (v < lo) begin
          v = clip32(lo + clip32(lo - v));
          step_flip = !step_flip;
        end else if (v > hi) begin
          v = hi;
        end
      end
      pbmc_pkg::LmUpDown: begin
        if (v > hi) begin
          v = clip32(hi - clip32(v - hi));
          step_flip = !step_flip;
        end else if (v < lo) begin
          v = lo;
        end
      end
      default: ;  // unassigned modes keep the plain sum
    endcase
    count_val = pbmc_pkg::value_t'(v);
  endfunction

  // state update for one accepted word, returns the result it causes
  function automatic count_word_t count_after_word(input logic m, input pbmc_pkg::ctl_e cv);
    count_word_t w;
    logic        stepped;
    stepped = 1'b0;
    if (m == ModeCtlWrite) begin
      // control write keeps the prescaler
      ctl_state = cv;
    end else if (ctl_state != pbmc_pkg::CtlStopped) begin
      prescale_cnt = prescale_cnt + 1'b1;
      if (prescale_cnt >= cfg_period) begin
        prescale_cnt = '0;
        stepped      = 1'b1;
        case (ctl_state)
          pbmc_pkg::CtlRun: bounded_step();
          pbmc_pkg::CtlRewind: begin
            count_val = cfg_low;
            ctl_state = pbmc_pkg::CtlRun;
          end
          default: begin
            count_val = cfg_high;
            ctl_state = pbmc_pkg::CtlRun;
          end
        endcase
      end
    end
    w.count   = count_val;
    w.stepped = stepped;
    w.ctl     = ctl_state;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // clock, watchdog, result side
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop if the run hangs
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL prescaled_bounded_mode_counter_top");
    $finish;
  end

  // result ready, stalled at random
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !(receiver_gaps && $urandom_range(99) < 13);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    count_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("result word with nothing expected", out_ch.count_value, '0);
      end else begin
        want = pending_counts.pop_front();
        if (out_ch.count_value !== want.count)
          report_mismatch("count_value", out_ch.count_value, want.count);
        if (out_ch.stepped !== want.stepped)
          report_mismatch("stepped", 32'(out_ch.stepped), 32'(want.stepped));
        if (out_ch.control_now !== want.ctl)
          report_mismatch("control_now", 32'(out_ch.control_now), 32'(want.ctl));
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side and register port
  // --------------------------------------------------------------------------

  // send one word; valid stays up into the next word when no gap is drawn
  task automatic send_word(input logic m, input pbmc_pkg::ctl_e cv);
    while (sender_gaps && $urandom_range(99) < 13) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= m;
    in_ch.control_value <= cv;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    pending_counts.push_back(count_after_word(m, cv));
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_for_counts();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  // setup then access phase, register taken at the access edge
  task automatic write_reg(input pbmc_pkg::reg_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      pbmc_pkg::RegPeriod:    cfg_period = data[pbmc_pkg::PeriodWidth-1:0];
      pbmc_pkg::RegStepSize: begin
        cfg_step  = data;
        step_flip = 1'b0;  // new step restarts in the forward direction
      end
      pbmc_pkg::RegLowLimit:  cfg_low = data;
      pbmc_pkg::RegHighLimit: cfg_high = data;
      default:                cfg_lmode = data[2:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset registers: period ten, unit step, limits 0 and 100
  task automatic test_reset_state();
    int i;
    for (i = 0; i < 10; i++) send_word(ModeTick, pbmc_pkg::CtlStopped);
  endtask

  // every control state, with a step on each tick and a shuttle bounce
  task automatic test_control_states();
    wait_for_counts();
    write_reg(pbmc_pkg::RegPeriod, 32'd0);
    write_reg(pbmc_pkg::RegStepSize, 32'd4);
    write_reg(pbmc_pkg::RegLowLimit, -32'sd5);
    write_reg(pbmc_pkg::RegHighLimit, 32'sd5);
    write_reg(pbmc_pkg::RegLimitMode, 32'(pbmc_pkg::LmShuttle));
    send_word(ModeCtlWrite, pbmc_pkg::CtlStopped);
    send_word(ModeTick, pbmc_pkg::CtlRun);           // stopped tick changes nothing
    send_word(ModeCtlWrite, pbmc_pkg::CtlRewind);
    send_word(ModeTick, pbmc_pkg::CtlFfwd);          // rewind loads low limit
    send_word(ModeCtlWrite, pbmc_pkg::CtlFfwd);
    send_word(ModeTick, pbmc_pkg::CtlRewind);        // fast-forward loads high limit
    send_word(ModeCtlWrite, pbmc_pkg::CtlRun);
    send_word(ModeTick, pbmc_pkg::CtlStopped);       // past the top, reflects and reverses
    send_word(ModeTick, pbmc_pkg::CtlStopped);
  endtask

  // full-range limits and steps, equal limits, crossed limits, unassigned mode
  task automatic test_limit_extremes();
    wait_for_counts();
    write_reg(pbmc_pkg::RegLowLimit, MinValue);
    write_reg(pbmc_pkg::RegHighLimit, MaxValue);
    write_reg(pbmc_pkg::RegStepSize, MinValue);
    write_reg(pbmc_pkg::RegLimitMode, 32'(pbmc_pkg::LmLoop));
    send_word(ModeTick, pbmc_pkg::CtlRun);
    send_word(ModeTick, pbmc_pkg::CtlRun);           // saturates at the bottom
    wait_for_counts();
    write_reg(pbmc_pkg::RegLowLimit, 32'sd7);
    write_reg(pbmc_pkg::RegHighLimit, 32'sd7);
    write_reg(pbmc_pkg::RegStepSize, MaxValue);
    send_word(ModeTick, pbmc_pkg::CtlRun);
    wait_for_counts();
    write_reg(pbmc_pkg::RegLowLimit, 32'sd10);
    write_reg(pbmc_pkg::RegHighLimit, -32'sd10);
    write_reg(pbmc_pkg::RegLimitMode, 32'd7);
    write_reg(pbmc_pkg::RegStepSize, 32'sd3);
    send_word(ModeTick, pbmc_pkg::CtlRun);
  endtask

  // random phases: new register settings between phases, mostly ticks inside
  task automatic test_random_phases();
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      words;
    int unsigned      i;
    pbmc_pkg::value_t lo;
    pbmc_pkg::value_t hi;
    pbmc_pkg::value_t st;
    logic [31:0]      per;
    sent  = 0;
    phase = 0;
    while (sent < RandomWords) begin
      wait_for_counts();
      // a stretch of phases with no idling on either side
      sender_gaps   = !(phase >= 4 && phase < 8);
      receiver_gaps = sender_gaps;

      if (phase == 0 || $urandom_range(1)) begin
        case ($urandom_range(19))
          0:       per = 32'hffff;
          1, 2:    per = $urandom_range(40, 8);
          default: per = $urandom_range(3);
        endcase
        write_reg(pbmc_pkg::RegPeriod, per);
      end
      if (phase == 0 || $urandom_range(2) != 0) begin
        case ($urandom_range(11))
          0:       st = MinValue;
          1:       st = MaxValue;
          2:       st = $urandom;
          3:       st = pbmc_pkg::value_t'($urandom_range(100)) - 50;
          default: st = pbmc_pkg::value_t'($urandom_range(16)) - 8;
        endcase
        write_reg(pbmc_pkg::RegStepSize, st);
      end
      if (phase == 0 || $urandom_range(9) < 7) begin
        case ($urandom_range(11))
          0: begin
            lo = MinValue;
            hi = MaxValue;
          end
          1: begin
            lo = $urandom;
            hi = $urandom;
          end
          2: begin
            lo = pbmc_pkg::value_t'($urandom_range(20)) - 10;
            hi = lo;
          end
          3: begin
            // crossed limits
            lo = pbmc_pkg::value_t'($urandom_range(30));
            hi = lo - pbmc_pkg::value_t'($urandom_range(30, 1));
          end
          4: begin
            hi = MaxValue - pbmc_pkg::value_t'($urandom_range(5));
            lo = hi - pbmc_pkg::value_t'($urandom_range(40, 1));
          end
          5: begin
            lo = MinValue + pbmc_pkg::value_t'($urandom_range(5));
            hi = lo + pbmc_pkg::value_t'($urandom_range(40, 1));
          end
          default: begin
            lo = pbmc_pkg::value_t'($urandom_range(60)) - 30;
            hi = lo + pbmc_pkg::value_t'($urandom_range(60, 1));
          end
        endcase
        write_reg(pbmc_pkg::RegLowLimit, lo);
        write_reg(pbmc_pkg::RegHighLimit, hi);
      end
      if (phase == 0 || $urandom_range(1)) begin
        if ($urandom_range(9) < 8) write_reg(pbmc_pkg::RegLimitMode, $urandom_range(4));
        else write_reg(pbmc_pkg::RegLimitMode, $urandom_range(7, 5));
      end

      words = 25 + $urandom_range(30);
      for (i = 0; i < words; i++) begin
        // hold off the sender once until the block has fully drained
        if (phase == 9 && i == words / 2) wait_for_counts();
        if ($urandom_range(99) < 18)
          send_word(ModeCtlWrite, $urandom_range(1) ? pbmc_pkg::CtlRun :
                                  pbmc_pkg::ctl_e'($urandom_range(3)));
        else
          send_word(ModeTick, pbmc_pkg::ctl_e'($urandom_range(3)));
        sent++;
      end
      phase++;
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    // every input known from time zero
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= ModeTick;
    in_ch.control_value <= pbmc_pkg::CtlRun;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    reset_counter_model();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_control_states();
    test_limit_extremes();
    test_random_phases();

    // drain, then go on watching the result side to catch stray result words
    wait_for_counts();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS prescaled_bounded_mode_counter_top");
    end else begin
      $display("FAIL prescaled_bounded_mode_counter_top");
    end
    $finish;
  end

endmodule
